FILE: rtl/core/rom_ram_bank_mapper_unit_assert.svh
// Assertion helpers for the bank mapper.
`ifndef ROM_RAM_BANK_MAPPER_UNIT_ASSERT_SVH
`define ROM_RAM_BANK_MAPPER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define RRBM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rom_ram_bank_mapper check failed: %m");

// Checked at every edge, reset included.
`define RRBM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("rom_ram_bank_mapper check failed: %m");

`endif

FILE: rtl/core/rrbm_pkg.sv
`default_nettype none

package rrbm_pkg;

  // Store depths
  localparam int unsigned ROM_DEPTH = 131072;
  localparam int unsigned RAM_DEPTH = 32768;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  // Field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BUS_AW     = 16;
  localparam int unsigned IMG_AW     = 17;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned BANKS_W    = 8;
  localparam int unsigned RSZ_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned BANK_W     = 7;
  localparam int unsigned PAGE_W     = 2;

  // ROM offset: bank number over a 16K window
  localparam int unsigned ROM_WIN_W = 14;
  localparam int unsigned ROM_OFF_W = BANK_W + ROM_WIN_W;
  // RAM offset: page over an 8K window; one extra bit for compares
  localparam int unsigned RAM_WIN_W = 13;
  localparam int unsigned RAM_OFF_W = PAGE_W + RAM_WIN_W;
  localparam int unsigned RAM_SZ_W  = RAM_OFF_W + 1;

  localparam logic [DATA_W-1:0]   DATA_FILL   = 8'hFF;
  localparam logic [3:0]          RAM_EN_KEY  = 4'hA;
  localparam logic [RAM_SZ_W-1:0] RAM_SZ_8K   = RAM_SZ_W'(16'h2000);
  localparam logic [RAM_SZ_W-1:0] RAM_SZ_FULL = RAM_SZ_W'(RAM_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LOAD  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROM_BANKS = 1'b0,
    CFG_RAM_SIZE  = 1'b1
  } cfg_idx_e;

  localparam logic [RSZ_W-1:0] RSZ_8K      = 3'd2;
  localparam logic [RSZ_W-1:0] RSZ_FULL_LO = 3'd3;
  localparam logic [RSZ_W-1:0] RSZ_FULL_MI = 3'd4;
  localparam logic [RSZ_W-1:0] RSZ_FULL_HI = 3'd5;

  // Bus write decode on address bits [15:13]
  localparam logic [2:0] WR_RAM_EN   = 3'b000;
  localparam logic [2:0] WR_BANK_LO  = 3'b001;
  localparam logic [2:0] WR_BANK_HI  = 3'b010;
  localparam logic [2:0] WR_MODE     = 3'b011;
  localparam logic [2:0] RG_RAM      = 3'b101;

  // Source of a pending result
  typedef enum logic [1:0] {
    SEL_FILL,
    SEL_ROM,
    SEL_RAM
  } rsel_e;

endpackage

`default_nettype wire

FILE: rtl/core/rrbm_ram.sv
`default_nettype none

module rrbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // read data holds until the next read
  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/rom_ram_bank_mapper_unit.sv
`default_nettype none

// Bank-switching cartridge mapper with its own ROM image store and 32K banked
// RAM. Each request is a bus read, a bus write or a ROM image load byte, and
// each produces exactly one read_data result (0xFF for anything but a mapped
// read). After reset the RAM is swept to zero, one byte per cycle: in_ready_o
// stays low until all RAM_DEPTH (32768) bytes are cleared; configuration
// writes are taken at any time. Then a request is taken every cycle as long
// as results are drained: request addresses go straight into the ROM and RAM
// ports at accept; the registered read data moves on into the output
// register once that is free or being drained, and the output register
// offers it on the result channel. Control registers and RAM writes
// commit at the accept edge, so a following request always sees them; no
// forwarding is needed. ROM bytes must be loaded before they are read.
module rom_ram_bank_mapper_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [rrbm_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [rrbm_pkg::BUS_AW-1:0]      bus_address_i,
  input  wire logic [rrbm_pkg::IMG_AW-1:0]      image_address_i,
  input  wire logic [rrbm_pkg::DATA_W-1:0]      data_in_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [rrbm_pkg::DATA_W-1:0]      read_data_o,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [rrbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rrbm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rrbm_pkg::*;

  `include "rom_ram_bank_mapper_unit_assert.svh"

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [BANKS_W-1:0] rom_banks_q, rom_banks_d;
  logic [RSZ_W-1:0]   ram_code_q, ram_code_d;

  always_comb begin
    rom_banks_d = rom_banks_q;
    ram_code_d  = ram_code_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROM_BANKS: rom_banks_d = cfg_data_i[BANKS_W-1:0];
        CFG_RAM_SIZE:  ram_code_d  = cfg_data_i[RSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state and handshake
  // ---------------------------------------------------------------------------
  logic [BANK_W-1:0] bank_q, bank_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic              ram_en_q, ram_en_d;
  logic              mode_q, mode_d;

  // RAM clearing sweep
  logic [RAM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_done_q, clr_done_d;

  // one request in flight between memory read and output register
  logic              pend_q, pend_d;
  rsel_e             pend_sel_q, pend_sel_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  logic pend_move;
  logic in_fire;

  // pending result moves on when the output register is free or being drained
  assign pend_move  = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = clr_done_q && (!pend_q || pend_move);
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Address decode
  // ---------------------------------------------------------------------------
  logic [BANK_W-1:0]    win_bank;
  logic [ROM_OFF_W-1:0] rom_off;
  logic                 rom_ok;
  logic                 is_rom;
  logic                 is_ram;
  logic [RAM_OFF_W-1:0] ram_off;
  logic [RAM_SZ_W-1:0]  ram_size;
  logic                 ram_ok;
  logic [ROM_OFF_W:0]   img_ext;
  logic                 img_ok;

  assign is_rom   = (bus_address_i[BUS_AW-1] == 1'b0);
  assign is_ram   = (bus_address_i[BUS_AW-1 -: 3] == RG_RAM);
  // fixed window reads bank 0, switched window reads the bank register
  assign win_bank = bus_address_i[ROM_WIN_W] ? bank_q : '0;
  assign rom_off  = {win_bank, bus_address_i[ROM_WIN_W-1:0]};
  // offset below image size: bank below bank count and inside the store
  assign rom_ok   = ({1'b0, win_bank} < rom_banks_q)
                 && ({1'b0, rom_off} < (ROM_OFF_W + 1)'(ROM_DEPTH));

  always_comb begin
    unique case (ram_code_q)
      RSZ_8K:                                 ram_size = RAM_SZ_8K;
      RSZ_FULL_LO, RSZ_FULL_MI, RSZ_FULL_HI:  ram_size = RAM_SZ_FULL;
      default:                                ram_size = '0;
    endcase
  end

  assign ram_off = {page_q, bus_address_i[RAM_WIN_W-1:0]};
  assign ram_ok  = ram_en_q && (ram_size != '0) && ({1'b0, ram_off} < ram_size);

  assign img_ext = (ROM_OFF_W + 1)'(image_address_i);
  assign img_ok  = img_ext < (ROM_OFF_W + 1)'(ROM_DEPTH);

  // ---------------------------------------------------------------------------
  // Request execution
  // ---------------------------------------------------------------------------
  logic rom_re, rom_we;
  logic ram_re, ram_bus_we;

  always_comb begin
    bank_d     = bank_q;
    page_d     = page_q;
    ram_en_d   = ram_en_q;
    mode_d     = mode_q;
    rom_re     = 1'b0;
    rom_we     = 1'b0;
    ram_re     = 1'b0;
    ram_bus_we = 1'b0;
    pend_sel_d = pend_sel_q;

    if (in_fire) begin
      pend_sel_d = SEL_FILL;
      unique case (func_i)
        FUNC_READ: begin
          if (is_rom && rom_ok) begin
            rom_re     = 1'b1;
            pend_sel_d = SEL_ROM;
          end else if (is_ram && ram_ok) begin
            ram_re     = 1'b1;
            pend_sel_d = SEL_RAM;
          end
        end
        FUNC_WRITE: begin
          unique case (bus_address_i[BUS_AW-1 -: 3])
            WR_RAM_EN:  ram_en_d = (data_in_i[3:0] == RAM_EN_KEY);
            WR_BANK_LO: begin
              // a zero low field is written as 1, so bank 0 is never selected
              if (data_in_i[4:0] == '0) begin
                bank_d = {bank_q[BANK_W-1:5], 5'd1};
              end else begin
                bank_d = {bank_q[BANK_W-1:5], data_in_i[4:0]};
              end
            end
            WR_BANK_HI: begin
              if (!mode_q) begin
                bank_d = {data_in_i[1:0], bank_q[4:0]};
              end else begin
                page_d = data_in_i[PAGE_W-1:0];
              end
            end
            WR_MODE:    mode_d = data_in_i[0];
            RG_RAM:     ram_bus_we = ram_ok;
            default: ;
          endcase
        end
        FUNC_LOAD: rom_we = img_ok;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] rom_rdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  rrbm_ram #(
    .Width(DATA_W),
    .Depth(ROM_DEPTH)
  ) u_rom_store (
    .clk_i  (clk_i),
    .we_i   (rom_we),
    .waddr_i(img_ext[ROM_AW-1:0]),
    .wdata_i(data_in_i),
    .re_i   (rom_re),
    .raddr_i(rom_off[ROM_AW-1:0]),
    .rdata_o(rom_rdata)
  );

  // the clearing sweep owns the write port until it is done
  assign ram_we    = !clr_done_q || ram_bus_we;
  assign ram_waddr = clr_done_q ? ram_off[RAM_AW-1:0] : clr_cnt_q;
  assign ram_wdata = clr_done_q ? data_in_i : '0;

  rrbm_ram #(
    .Width(DATA_W),
    .Depth(RAM_DEPTH)
  ) u_ram_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_off[RAM_AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1)) begin
        clr_done_d = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result path
  // ---------------------------------------------------------------------------
  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_move) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      case (pend_sel_q)
        SEL_ROM: out_data_d = rom_rdata;
        SEL_RAM: out_data_d = ram_rdata;
        default: out_data_d = DATA_FILL;
      endcase
    end
    if (in_fire) begin
      pend_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_banks_q <= BANKS_W'(8);
      ram_code_q  <= '0;
      bank_q      <= BANK_W'(1);
      page_q      <= '0;
      ram_en_q    <= 1'b0;
      mode_q      <= 1'b0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      pend_sel_q  <= SEL_FILL;
      out_valid_q <= 1'b0;
    end else begin
      rom_banks_q <= rom_banks_d;
      ram_code_q  <= ram_code_d;
      bank_q      <= bank_d;
      page_q      <= page_d;
      ram_en_q    <= ram_en_d;
      mode_q      <= mode_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_done_q  <= clr_done_d;
      pend_q      <= pend_d;
      pend_sel_q  <= pend_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the low bank field can never select bank 0
  `RRBM_ASSERT_ALWAYS(a_bank_low_nonzero, rst_ni |-> (bank_q[4:0] != '0))
  // no request is taken while the RAM sweep runs
  `RRBM_ASSERT(a_no_accept_in_clear, !clr_done_q |-> !in_ready_o)
  // every accepted request becomes pending
  `RRBM_ASSERT(a_fire_pends, in_fire |=> pend_q)
  // a blocked pending result keeps its source
  `RRBM_ASSERT(a_pend_holds, pend_q && !pend_move |=> pend_q && $stable(pend_sel_q))

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Testbench for the bank mapper: directed ROM banking and RAM guard checks,
// then randomized bus traffic over several size configurations. Every
// request is predicted in order by a behavioral copy of the mapper, and
// each read_data result is matched against the oldest pending prediction.
module tb;
  import rrbm_pkg::*;

  // Spare func code: the block must answer it with fill and change nothing
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i          = '0;
  logic [BUS_AW-1:0]     bus_address_i   = '0;
  logic [IMG_AW-1:0]     image_address_i = '0;
  logic [DATA_W-1:0]     data_in_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b1;
  logic [DATA_W-1:0]     read_data_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  rom_ram_bank_mapper_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .bus_address_i  (bus_address_i),
    .image_address_i(image_address_i),
    .data_in_i      (data_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Mapper mirror: control state, config copies and both stores
  // ---------------------------------------------------------------------
  logic [BANK_W-1:0] bank_sel  = 7'd1;
  logic [PAGE_W-1:0] ram_page  = '0;
  bit                ram_on    = 1'b0;
  bit                mode_sel  = 1'b0;
  logic [7:0]        rom_banks = 8'd8;
  logic [RSZ_W-1:0]  ram_code  = '0;

  bit [7:0] rom_image [ROM_DEPTH];
  bit       rom_loaded [ROM_DEPTH];  // ROM bytes may only be read once loaded
  bit [7:0] ram_image [RAM_DEPTH];   // RAM is swept to zero after reset

  logic [DATA_W-1:0] expected_read_data [$];

  int unsigned fault_count = 0;
  logic [DATA_W-1:0] want;

  // When set, neither side idles: back-to-back requests and results
  bit calm = 1'b0;
  int unsigned stall_left = 0;

  // Window offsets that random traffic keeps coming back to, edges included
  logic [13:0] hot_offsets [8] = '{14'h0000, 14'h3FFF, 14'h1FFF, 14'h2000,
                                   14'h0001, 14'h2AAA, 14'h1555, 14'h3FFE};

  // ---------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_wait();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Loaded image size, capped at the ROM store depth
  function automatic int image_bytes();
    int n;
    n = int'(rom_banks) * 32'h4000;
    return (n > int'(ROM_DEPTH)) ? int'(ROM_DEPTH) : n;
  endfunction

  function automatic int ram_limit();
    case (ram_code)
      RSZ_8K:                               return int'(RAM_SZ_8K);
      RSZ_FULL_LO, RSZ_FULL_MI, RSZ_FULL_HI: return int'(RAM_DEPTH);
      default:                              return 0;
    endcase
  endfunction

  // ROM byte behind a bus address, or -1 when unmapped or past the image
  function automatic int rom_offset(input logic [BUS_AW-1:0] addr);
    int off;
    if (addr[15]) begin
      return -1;
    end
    off = int'(addr[13:0]);
    if (addr[14]) begin
      off = off + int'(bank_sel) * 32'h4000;
    end
    return (off < image_bytes()) ? off : -1;
  endfunction

  // RAM byte behind a bus address, or -1 when disabled, absent or too far
  function automatic int ram_offset(input logic [BUS_AW-1:0] addr);
    int lim;
    int off;
    lim = ram_limit();
    if (!ram_on || lim == 0 || addr[15:13] != RG_RAM) begin
      return -1;
    end
    off = int'(addr[12:0]) + int'(ram_page) * 32'h2000;
    return (off < lim) ? off : -1;
  endfunction

  // Applies one request to the mirror and returns the byte it must produce
  function automatic logic [DATA_W-1:0] mapper_response(
    input logic [FUNC_W-1:0] fn,
    input logic [BUS_AW-1:0] addr,
    input logic [IMG_AW-1:0] img,
    input logic [DATA_W-1:0] data
  );
    int rom_off;
    int ram_off;
    logic [DATA_W-1:0] rd;
    rd = DATA_FILL;
    rom_off = rom_offset(addr);
    ram_off = ram_offset(addr);
    case (fn)
      FUNC_READ: begin
        if (rom_off >= 0) begin
          rd = rom_image[rom_off];
        end else if (ram_off >= 0) begin
          rd = ram_image[ram_off];
        end
      end
      FUNC_WRITE: begin
        case (addr[15:13])
          WR_RAM_EN:  ram_on = (data[3:0] == RAM_EN_KEY);
          // a zero low field is still written as 1
          WR_BANK_LO: bank_sel[4:0] = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
          WR_BANK_HI: begin
            if (mode_sel) begin
              ram_page = data[1:0];
            end else begin
              bank_sel[6:5] = data[1:0];
            end
          end
          WR_MODE:    mode_sel = data[0];
          RG_RAM: begin
            if (ram_off >= 0) begin
              ram_image[ram_off] = data;
            end
          end
          default: ;
        endcase
      end
      FUNC_LOAD: begin
        if (int'(img) < int'(ROM_DEPTH)) begin
          rom_image[img]  = data;
          rom_loaded[img] = 1'b1;
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  // Called right after the previous acceptance (or while idle). With no gap,
  // valid stays high and only the payload moves on, so valid never takes two
  // updates in one step.
  task automatic issue_request(
    input logic [FUNC_W-1:0] fn,
    input logic [BUS_AW-1:0] addr,
    input logic [IMG_AW-1:0] img,
    input logic [DATA_W-1:0] data
  );
    int unsigned gap;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= fn;
    bus_address_i   <= addr;
    image_address_i <= img;
    data_in_i       <= data;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: predict in acceptance order
    expected_read_data.push_back(mapper_response(fn, addr, img, data));
  endtask

  // A ROM-backed read of a byte never loaded is illegal; load it first
  task automatic bus_read(input logic [BUS_AW-1:0] addr);
    int off;
    off = rom_offset(addr);
    if (off >= 0 && !rom_loaded[off]) begin
      issue_request(FUNC_LOAD, 16'($urandom), 17'(off), 8'($urandom));
    end
    issue_request(FUNC_READ, addr, 17'($urandom), 8'($urandom));
  endtask

  task automatic bus_write(input logic [BUS_AW-1:0] addr, input logic [DATA_W-1:0] data);
    issue_request(FUNC_WRITE, addr, 17'($urandom), data);
  endtask

  // Drop valid and wait for every pending result
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_read_data.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Only called while idle
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_ROM_BANKS: rom_banks = value;
      CFG_RAM_SIZE:  ram_code  = value[RSZ_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [BUS_AW-1:0] unmapped_addr();
    if ($urandom_range(0, 1) != 0) begin
      return {3'b100, 13'($urandom)};
    end
    return {2'b11, 14'($urandom)};
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, then the in-order check
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      stall_left = pick_wait();
      out_ready_i <= (stall_left == 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_read_data.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("%0t: read_data %02h with no request pending", $realtime, read_data_o);
        end
      end else begin
        want = expected_read_data.pop_front();
        if (read_data_o !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: read_data mismatch, expected %02h got %02h",
                     $realtime, want, read_data_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Two-bank image: fixed area, bank 1, bank 0 remap, banks past the image
  task automatic test_rom_banking();
    cfg_write(CFG_ROM_BANKS, 8'd2);   // taken during the RAM sweep
    bus_read(16'h0000);
    bus_read(16'h3FFF);
    bus_read(16'h7FFF);               // bank 1 is the last bank
    bus_write(16'h2000, 8'hE0);       // low field 0 -> bank 1
    bus_read(16'h7FFF);
    bus_write(16'h3FFF, 8'h02);       // bank 2: past the image
    bus_read(16'h4000);
    bus_write(16'h4000, 8'h03);       // mode 0: upper bank bits
    bus_write(16'h2000, 8'h01);
    bus_read(16'h4000);               // bank 0x61, fill
    bus_write(16'h5FFF, 8'h00);
  endtask

  // 8K RAM: enable key, paging past the RAM end, disable, unmapped areas
  task automatic test_ram_guards();
    quiesce();
    cfg_write(CFG_ROM_BANKS, 8'd128);
    cfg_write(CFG_RAM_SIZE, 8'(RSZ_8K));
    bus_read(16'hA000);               // disabled
    bus_write(16'h0000, 8'h3A);       // only the low nibble is the key
    bus_write(16'hA000, 8'hA5);
    bus_read(16'hA000);
    bus_read(16'hBFFF);               // still cleared
    bus_write(16'h6000, 8'hFF);       // mode 1
    bus_write(16'h5FFF, 8'h01);       // page 1 is past 8K
    bus_read(16'hA000);
    bus_write(16'hBFFF, 8'h11);       // refused
    bus_write(16'h4000, 8'h00);
    bus_write(16'h7FFF, 8'h00);       // mode 0
    bus_read(16'hBFFF);
    bus_write(16'h1FFF, 8'h0B);       // wrong key disables
    bus_read(16'hA000);
    bus_read(16'h8000);
    bus_read(16'hFFFF);
    bus_write(16'hC000, 8'h77);
    issue_request(FUNC_SPARE, 16'hFFFF, 17'h1FFFF, 8'hFF);
    issue_request(FUNC_LOAD, 16'h0000, 17'h1FFFF, 8'h00);
  endtask

  // One random request; control writes are biased so that banks stay
  // mostly inside the image and RAM stays mostly enabled
  task automatic random_request();
    int unsigned pick;
    int unsigned kind;
    logic [13:0] low;
    logic [DATA_W-1:0] d;
    logic [IMG_AW-1:0] img;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    low  = ($urandom_range(0, 9) < 6) ? hot_offsets[$urandom_range(0, 7)] : 14'($urandom);
    d    = 8'($urandom);
    img  = 17'($urandom);
    if (pick < 45) begin
      case (kind)
        0, 1, 2: bus_read({2'b00, low});
        3, 4, 5: bus_read({2'b01, low});
        6, 7, 8: bus_read({RG_RAM, low[12:0]});
        default: bus_read(unmapped_addr());
      endcase
    end else if (pick < 80) begin
      case (kind)
        0, 1: begin
          if ($urandom_range(0, 9) < 7) begin
            d[3:0] = RAM_EN_KEY;
          end
          bus_write({WR_RAM_EN, 13'($urandom)}, d);
        end
        2, 3: begin
          if ($urandom_range(0, 9) < 6) begin
            d[4:0] = 5'($urandom_range(0, 7));
          end
          bus_write({WR_BANK_LO, 13'($urandom)}, d);
        end
        4: begin
          if ($urandom_range(0, 9) < 7) begin
            d[1:0] = 2'b00;
          end
          bus_write({WR_BANK_HI, 13'($urandom)}, d);
        end
        5:       bus_write({WR_MODE, 13'($urandom)}, d);
        6, 7, 8: bus_write({RG_RAM, low[12:0]}, d);
        default: bus_write(unmapped_addr(), d);
      endcase
    end else if (pick < 95) begin
      // half the loads land where reads tend to go
      if (kind < 5) begin
        img = {3'($urandom_range(0, 7)), low};
      end
      issue_request(FUNC_LOAD, 16'($urandom), img, d);
    end else begin
      issue_request(FUNC_SPARE, 16'($urandom), img, d);
    end
  endtask

  // Random traffic under a series of sizes; 0 in the bank list draws one
  task automatic test_random_phases();
    int unsigned banks [9] = '{2, 128, 8, 3, 9, 0, 2, 128, 16};
    int unsigned codes [9] = '{0, 5, 2, 3, 4, 1, 2, 3, 5};
    int unsigned nb;
    for (int p = 0; p < 9; p++) begin
      quiesce();
      nb = (banks[p] != 0) ? banks[p] : $urandom_range(2, 128);
      cfg_write(CFG_ROM_BANKS, 8'(nb));
      cfg_write(CFG_RAM_SIZE, 8'(codes[p]));
      for (int n = 0; n < 185; n++) begin
        if (n % 64 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        random_request();
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_rom_banking();
    test_ram_guards();
    test_random_phases();
    quiesce();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
